FILE: design/lcfp_pkg.sv
// Shared types and constants for the length/checksum frame parser.
`default_nettype none

package lcfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 2;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_CHK  = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] index;
      logic [BYTE_W-1:0] length;
   } result_type;

endpackage

`default_nettype wire

FILE: design/lcfp_channels.sv
// Valid/ready channel interfaces for the request, response and control-register words.
`default_nettype none

interface lcfp_req_if;
   logic                          valid;
   logic                          ready;
   logic [lcfp_pkg::BYTE_W-1:0]   rx_byte;
   logic                          buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface lcfp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lcfp_pkg::KIND_W-1:0]   result_kind;
   logic [lcfp_pkg::BYTE_W-1:0]   data_byte;
   logic [lcfp_pkg::BYTE_W-1:0]   byte_index;
   logic [lcfp_pkg::BYTE_W-1:0]   frame_length;

   modport source (output valid, output result_kind, output data_byte,
                   output byte_index, output frame_length, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input byte_index, input frame_length, output ready);
endinterface

interface lcfp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lcfp_pkg::BYTE_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/length_checksum_frame_parser_core.sv
// Top level of the start/length/payload/checksum frame parser.
`default_nettype none

// The parser takes one received byte per word on req_bus and hunts for the
// configured start byte. That byte is followed by a length byte L, then L
// payload bytes, then a checksum byte equal to L plus the payload bytes,
// modulo 256. Each payload byte leaves on rsp_bus as it arrives, tagged with
// its position and the frame length. The checksum byte yields a good or
// mismatch verdict, and a word marked as the buffer end in the middle of a
// frame yields a truncated verdict instead of its normal result. After any
// verdict the parser hunts again. A length of zero is a valid frame. The
// block takes one word per clock cycle unless the receiver holds off a
// waiting result. A word passes through the input register and then the
// result register, with the parsing logic between them. The input register
// advances whenever the result register is empty or is being emptied in the
// same cycle, so a result taken in that cycle does not stop the next word
// from being accepted. The start byte is written through csr_bus, which is
// always ready; it should only be changed while no word is in flight, and a
// change takes effect at the next hunt.
module length_checksum_frame_parser_core (
   input  wire logic       clock,
   input  wire logic       reset,
   lcfp_req_if.sink        req_bus,
   lcfp_rsp_if.source      rsp_bus,
   lcfp_csr_if.sink        csr_bus
);

   localparam int unsigned W = lcfp_pkg::BYTE_W;

   // Configuration register.
   logic [W-1:0]           start_ff;

   // Input register.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [W-1:0]           in_byte_ff;
   logic                   in_last_ff;

   // Parser state.
   lcfp_pkg::phase_type    phase_ff;
   lcfp_pkg::phase_type    phase_in;
   logic [W-1:0]           len_ff;
   logic [W-1:0]           len_in;
   logic [W-1:0]           count_ff;
   logic [W-1:0]           count_in;
   logic [W-1:0]           sum_ff;
   logic [W-1:0]           sum_in;

   // Result register.
   logic                   out_valid_ff;
   logic                   out_valid_in;
   lcfp_pkg::result_type   out_ff;

   // Combinational results of the parsing logic.
   logic                   emit;
   lcfp_pkg::result_type   result;
   logic                   advance;
   logic                   req_take;
   logic                   is_start;
   logic [W-1:0]           count_next;

   // The word in the input register is consumed once the result register
   // can take whatever it produces.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign csr_bus.ready = 1'b1;

   assign is_start   = (in_byte_ff == start_ff);
   assign count_next = count_ff + W'(1);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            lcfp_pkg::PH_HUNT: begin
               if (is_start && !in_last_ff) begin
                  phase_in = lcfp_pkg::PH_LEN;
               end
            end
            lcfp_pkg::PH_LEN: begin
               if (in_last_ff) begin
                  phase_in = lcfp_pkg::PH_HUNT;
               end else if (in_byte_ff == '0) begin
                  phase_in = lcfp_pkg::PH_CHK;
               end else begin
                  phase_in = lcfp_pkg::PH_DATA;
               end
            end
            lcfp_pkg::PH_DATA: begin
               if (in_last_ff) begin
                  phase_in = lcfp_pkg::PH_HUNT;
               end else if (count_next == len_ff) begin
                  phase_in = lcfp_pkg::PH_CHK;
               end
            end
            lcfp_pkg::PH_CHK: begin
               phase_in = lcfp_pkg::PH_HUNT;
            end
            default: begin
               phase_in = lcfp_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // Result and frame bookkeeping for the word in the input register.
   always_comb begin
      emit          = 1'b0;
      result.kind   = lcfp_pkg::KIND_PAYLOAD;
      result.data   = in_byte_ff;
      result.index  = count_ff;
      result.length = len_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      if (advance) begin
         unique case (phase_ff)
            lcfp_pkg::PH_HUNT: begin
               if (is_start && in_last_ff) begin
                  emit          = 1'b1;
                  result.kind   = lcfp_pkg::KIND_TRUNC;
                  result.index  = '0;
                  result.length = '0;
               end
            end
            lcfp_pkg::PH_LEN: begin
               if (in_last_ff) begin
                  emit          = 1'b1;
                  result.kind   = lcfp_pkg::KIND_TRUNC;
                  result.index  = '0;
                  result.length = in_byte_ff;
                  len_in        = '0;
                  count_in      = '0;
                  sum_in        = '0;
               end else begin
                  len_in   = in_byte_ff;
                  count_in = '0;
                  sum_in   = in_byte_ff;
               end
            end
            lcfp_pkg::PH_DATA: begin
               emit = 1'b1;
               if (in_last_ff) begin
                  result.kind = lcfp_pkg::KIND_TRUNC;
                  len_in      = '0;
                  count_in    = '0;
                  sum_in      = '0;
               end else begin
                  count_in = count_next;
                  sum_in   = sum_ff + in_byte_ff;
               end
            end
            lcfp_pkg::PH_CHK: begin
               emit        = 1'b1;
               result.kind = (in_byte_ff == sum_ff) ? lcfp_pkg::KIND_GOOD
                                                    : lcfp_pkg::KIND_BAD;
               len_in      = '0;
               count_in    = '0;
               sum_in      = '0;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= lcfp_pkg::START_BYTE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= lcfp_pkg::PH_HUNT;
         len_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            start_ff <= csr_bus.data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.rx_byte;
         in_last_ff <= req_bus.buffer_end;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.result_kind  = out_ff.kind;
   assign rsp_bus.data_byte    = out_ff.data;
   assign rsp_bus.byte_index   = out_ff.index;
   assign rsp_bus.frame_length = out_ff.length;

   // A frame in its payload phase always has bytes still to come.
   a_data_count_below_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lcfp_pkg::PH_DATA) |-> (len_ff != '0 && count_ff < len_ff))
      else $error("payload phase with no payload bytes left");

   // A word held in the input register is not dropped before it is parsed.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word lost while stalled");

   // Every verdict sends the parser back to hunting.
   a_verdict_resumes_hunt: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && result.kind != lcfp_pkg::KIND_PAYLOAD)
         |=> (phase_ff == lcfp_pkg::PH_HUNT && sum_ff == '0))
      else $error("parser did not return to hunting after a verdict");

   // A new result is only loaded once the previous one has been taken.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> (!out_valid_ff || rsp_bus.ready))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: tb/lcfp_frame_checker.sv
// Checker that predicts the frame parser's results and compares them with the response channel.
module lcfp_frame_checker (
   input  wire logic clock,
   input  wire logic reset,
   lcfp_req_if       req_mon,
   lcfp_rsp_if       rsp_mon,
   lcfp_csr_if       csr_mon,
   output int        mismatch_count,
   output int        pending_count
);
   import lcfp_pkg::*;

   result_type        frame_results_q[$];
   phase_type         phase;
   logic [BYTE_W-1:0] start_value;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] taken;
   logic [BYTE_W-1:0] running_sum;
   int                results_seen;

   task automatic report_mismatch(input string detail);
      $display("%0t: mismatch on result %0d: %s", $realtime, results_seen, detail);
      mismatch_count++;
   endtask

   function automatic void restart_hunt();
      phase       = PH_HUNT;
      frame_len   = '0;
      taken       = '0;
      running_sum = '0;
   endfunction

   // Advances the parse state by one received word and queues the result it causes.
   task automatic parse_word(input logic [BYTE_W-1:0] rx, input logic last);
      result_type r;
      bit         emit;
      emit = 1'b0;
      case (phase)
         PH_HUNT: begin
            if (rx == start_value) begin
               if (last) begin
                  r    = '{KIND_TRUNC, rx, 8'd0, 8'd0};
                  emit = 1'b1;
                  restart_hunt();
               end else begin
                  phase = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (last) begin
               r    = '{KIND_TRUNC, rx, 8'd0, rx};
               emit = 1'b1;
               restart_hunt();
            end else begin
               frame_len   = rx;
               running_sum = rx;
               taken       = '0;
               phase       = (rx == '0) ? PH_CHK : PH_DATA;
            end
         end
         PH_DATA: begin
            emit = 1'b1;
            if (last) begin
               r = '{KIND_TRUNC, rx, taken, frame_len};
               restart_hunt();
            end else begin
               r           = '{KIND_PAYLOAD, rx, taken, frame_len};
               running_sum = running_sum + rx;
               taken       = taken + 1'b1;
               if (taken == frame_len) begin
                  phase = PH_CHK;
               end
            end
         end
         default: begin
            r    = '{(rx == running_sum) ? KIND_GOOD : KIND_BAD, rx, taken, frame_len};
            emit = 1'b1;
            restart_hunt();
         end
      endcase
      if (emit) begin
         frame_results_q.push_back(r);
      end
   endtask

   task automatic check_result();
      result_type want;
      results_seen++;
      if (frame_results_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result, kind %0d data %0d",
                                   rsp_mon.result_kind, rsp_mon.data_byte));
         return;
      end
      want = frame_results_q.pop_front();
      if (rsp_mon.result_kind !== want.kind) begin
         report_mismatch($sformatf("result_kind %0d, expected %0d",
                                   rsp_mon.result_kind, want.kind));
      end
      if (rsp_mon.data_byte !== want.data) begin
         report_mismatch($sformatf("data_byte %0d, expected %0d",
                                   rsp_mon.data_byte, want.data));
      end
      if (rsp_mon.byte_index !== want.index) begin
         report_mismatch($sformatf("byte_index %0d, expected %0d",
                                   rsp_mon.byte_index, want.index));
      end
      if (rsp_mon.frame_length !== want.length) begin
         report_mismatch($sformatf("frame_length %0d, expected %0d",
                                   rsp_mon.frame_length, want.length));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_value = START_BYTE_RESET;
         restart_hunt();
         frame_results_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            start_value = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_word(req_mon.rx_byte, req_mon.buffer_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
      end
      pending_count <= frame_results_q.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the frame parser testbench: clock, reset, stimulus phases and the final verdict.
module testbench;
   import lcfp_pkg::*;

   logic clock = 1'b0;
   logic reset;

   lcfp_req_if req_bus ();
   lcfp_rsp_if rsp_bus ();
   lcfp_csr_if csr_bus ();

   int                mismatch_count;
   int                pending_count;
   int                idle_pct;
   int                stall_pct;
   int                frame_words;
   logic [BYTE_W-1:0] start_code;

   length_checksum_frame_parser_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // The checker watches all three channels; this module only drives them.
   lcfp_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random; stall_pct is the share of cycles with ready low.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hands one word to the parser. Before it, the sender may sit idle for a few
   // cycles. The task returns at the edge where the word is accepted, with valid
   // still high, so the next word follows without a bubble.
   task automatic send_word(input logic [BYTE_W-1:0] value, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.rx_byte    <= value;
      req_bus.buffer_end <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Sends one frame with random payload. The buffer end mark goes on word
   // cut_at of the frame (0 is the start byte, 1 the length, the checksum comes
   // last); a negative cut_at sends the frame without it. A spoiled frame gets a
   // checksum that is off by a nonzero amount.
   task automatic send_frame(input int len, input int cut_at, input bit spoil);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] value;
      frame_words += len + 3;
      sum = len[BYTE_W-1:0];
      send_word(start_code, cut_at == 0);
      if (cut_at == 0) begin
         return;
      end
      send_word(len[BYTE_W-1:0], cut_at == 1);
      if (cut_at == 1) begin
         return;
      end
      for (int i = 0; i < len; i++) begin
         value = BYTE_W'($urandom_range(255));
         send_word(value, cut_at == i + 2);
         if (cut_at == i + 2) begin
            return;
         end
         sum = sum + value;
      end
      if (spoil) begin
         sum = sum ^ BYTE_W'($urandom_range(1, 255));
      end
      send_word(sum, cut_at == len + 2);
   endtask

   // A short burst of line noise. Now and then a stray start byte shows up, so
   // the next frame's start byte can be taken as a length and the parse go astray.
   task automatic send_noise();
      int count;
      count = $urandom_range(1, 4);
      repeat (count) begin
         if ($urandom_range(3) == 0) begin
            send_word(start_code, $urandom_range(3) == 0);
         end else begin
            send_word(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
         end
      end
   endtask

   // Mostly well-formed frames with small lengths, now and then a longer one,
   // plus bad checksums, cut-off frames and noise.
   task automatic run_random(input int words);
      int pick;
      int len;
      frame_words = 0;
      while (frame_words < words) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(8);
         if (pick < 65) begin
            send_frame(len, -1, 1'b0);
         end else if (pick < 75) begin
            send_frame(len, -1, 1'b1);
         end else if (pick < 88) begin
            send_frame(len, $urandom_range(len + 2), 1'b0);
         end else begin
            send_noise();
         end
      end
   endtask

   // Holds the sender off until every predicted result has come back. The
   // checker's count is registered, so the task steps the clock before its first look.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
   endtask

   // The start byte is only changed with the parser empty. A word that causes
   // no result may still sit in the two internal stages after the last result
   // has left, so the task lets it drain before the write.
   task automatic set_start_byte(input logic [BYTE_W-1:0] value);
      wait_drained();
      repeat (4) begin
         @(posedge clock);
      end
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
      start_code = value;
   endtask

   initial begin
      #(12 * 500000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int                idle_plan[4];
      int                stall_plan[4];
      logic [BYTE_W-1:0] start_plan[4];
      idle_plan  = '{0, 83, 0, 15};
      stall_plan = '{0, 0, 83, 15};
      start_plan = '{8'hFF, 8'h00, BYTE_W'($urandom_range(255)),
                     BYTE_W'($urandom_range(255))};
      idle_pct   = 0;
      stall_pct  = 0;
      start_code = START_BYTE_RESET;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.rx_byte    <= '0;
      req_bus.buffer_end <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.data       <= '0;
      repeat (7) begin
         @(posedge clock);
      end
      reset <= 1'b0;

      // Directed part, run with the start byte at its reset value.
      // While hunting, other bytes are dropped, even one marked as the buffer end.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      // Empty frame with the right checksum of zero, then with a wrong one.
      send_word(start_code, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(start_code, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b0);
      // All-ones payload; the checksum wraps around to zero.
      send_word(start_code, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      // The buffer ends on the start byte.
      send_word(start_code, 1'b1);
      // The buffer ends on the length byte.
      send_word(start_code, 1'b0);
      send_word(8'h05, 1'b1);
      // The buffer ends inside the payload.
      send_word(start_code, 1'b0);
      send_word(8'h03, 1'b0);
      send_word(8'h10, 1'b0);
      send_word(8'h20, 1'b1);
      // The buffer ends on the checksum, which still completes the frame.
      send_word(start_code, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b1);

      // Random phases, each with its own idling pattern and start byte. Halfway
      // through each phase the sender waits for the parser to drain completely.
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         set_start_byte(start_plan[p]);
         if (p == 0) begin
            // One frame of the largest length, so the byte index runs all the way up.
            send_frame(255, -1, 1'b0);
         end
         run_random(75);
         wait_drained();
         run_random(75);
      end

      wait_drained();
      repeat (8) begin
         @(posedge clock);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
